FILE: sv/bclp_pkg.sv
// Package for the button click and long-press classifier.
// Holds the register map, the configuration struct and the press event codes.
// No dependencies; every other file imports it.
`default_nettype none

package bclp_pkg;

  // Field widths of the stream items and registers.
  localparam int unsigned TimeW    = 16;
  localparam int unsigned ThreshW  = 24;
  localparam int unsigned CountW   = 25;
  localparam int unsigned TallyW   = 8;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 4;

  // Register index codes, taken from paddr[3:2].
  localparam logic [1:0] RegDebounceMs = 2'd0;
  localparam logic [1:0] RegLongPress  = 2'd1;
  localparam logic [1:0] RegClickGap   = 2'd2;

  // Register reset values.
  localparam logic [TimeW-1:0]   DebounceMsRst = 16'd9;
  localparam logic [ThreshW-1:0] LongPressRst  = 24'd1700000;
  localparam logic [ThreshW-1:0] ClickGapRst   = 24'd350000;

  // Counter limits.
  localparam logic [CountW-1:0]        CountMax = {CountW{1'b1}};
  localparam logic signed [TallyW-1:0] TallyMax = 8'sd127;
  localparam logic signed [TallyW-1:0] TallyLong = -8'sd1;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } press_event_e;

  typedef struct packed {
    logic [TimeW-1:0]   debounce_ms;
    logic [ThreshW-1:0] long_press_ticks;
    logic [ThreshW-1:0] click_gap_ticks;
  } cfg_t;

endpackage

`default_nettype wire

FILE: sv/bclp_core.sv
// Classifier state and its one-tick update: debouncer, hold counter, gap counter
// and click tally. Depends on bclp_pkg.
`default_nettype none

module bclp_core import bclp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic             key_level_i,
  input  wire logic [TimeW-1:0] time_ms_i,
  input  wire cfg_t             cfg_i,
  output press_event_e          event_o
);

  logic                     level_q, level_d;
  logic                     busy_q, busy_d;
  logic [TimeW-1:0]         stamp_q, stamp_d;
  logic [CountW-1:0]        held_q, held_d;
  logic [CountW-1:0]        gap_q, gap_d;
  logic signed [TallyW-1:0] tally_q, tally_d;

  logic [TimeW-1:0]  elapsed;
  logic [CountW-1:0] held_inc;
  logic [CountW-1:0] gap_inc;

  always_comb begin
    level_d  = level_q;
    busy_d   = busy_q;
    stamp_d  = stamp_q;
    held_d   = held_q;
    gap_d    = gap_q;
    tally_d  = tally_q;
    event_o  = EV_NONE;
    elapsed  = time_ms_i - stamp_q;
    held_inc = (held_q != CountMax) ? held_q + CountW'(1) : held_q;
    gap_inc  = (gap_q != CountMax) ? gap_q + CountW'(1) : gap_q;

    // Debounce: stamp the time of a new difference, sample the key once it expires.
    if ((key_level_i != level_q) && !busy_q) begin
      stamp_d = time_ms_i;
      busy_d  = 1'b1;
    end else if (busy_q && (elapsed > cfg_i.debounce_ms)) begin
      busy_d  = 1'b0;
      level_d = key_level_i;
    end

    if (level_d && !level_q) begin
      // Release edge counts a click.
      held_d = '0;
      if (tally_q != TallyMax) begin
        tally_d = tally_q + TallyW'(1);
      end
    end else if (!level_d && !level_q) begin
      held_d = held_inc;
      if (held_inc > CountW'(cfg_i.long_press_ticks)) begin
        tally_d = TallyLong;
        event_o = EV_LONG;
      end
    end else if (tally_q > 8'sd0) begin
      gap_d = gap_inc;
      if (gap_inc > CountW'(cfg_i.click_gap_ticks)) begin
        event_o = (tally_q == 8'sd1) ? EV_SINGLE : EV_DOUBLE;
        gap_d   = '0;
        tally_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b1;
      busy_q  <= 1'b0;
      stamp_q <= '0;
      held_q  <= '0;
      gap_q   <= '0;
      tally_q <= '0;
    end else if (step_i) begin
      level_q <= level_d;
      busy_q  <= busy_d;
      stamp_q <= stamp_d;
      held_q  <= held_d;
      gap_q   <= gap_d;
      tally_q <= tally_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/button_click_long_press_classifier_unit.sv
// Top level of the button click and long-press classifier: stream ports,
// register file on the APB-style port, input and result registers.
// Depends on bclp_pkg and bclp_core.
//
// Usage: every request on the slave stream is one poll tick of the key. Its
// tdata carries the raw active-low key level in bit 0 and the free-running
// millisecond time in bits 16:1. Every request yields exactly one result on
// the master stream, whose tdata carries the press event in bits 1:0
// (none, single, double or long press).
// A request is registered on acceptance, classified against the debouncer
// and counter state once the result register is free, and the result is
// registered in the result register that drives the master side. The
// classifier state updates in the same cycle, so while the receiver takes
// its results a new request can be taken every cycle: one request per clock.
// When the receiver stalls, the result register holds its request and the
// input register fills; the slave side then drops tready until the result
// is taken. No request is lost or repeated.
// Reset clears both valid flags and returns the debouncer to the released
// level with all counters at zero; the registers return to a debounce time
// of 9 ms, a long-press threshold of 1700000 ticks and a click gap of
// 350000 ticks. Registers are meant to be written only while the block is
// idle; writes to an address beyond the third register are ignored.
`default_nettype none

module button_click_long_press_classifier_unit import bclp_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Slave stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,  // [0] key_level, [16:1] time_ms
  // Master stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,  // [1:0] press_event
  // Configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0]      prdata,
  output logic                     pready
);

  cfg_t cfg_q;
  logic cfg_we;

  // Input register.
  logic             in_valid_q;
  logic             key_q;
  logic [TimeW-1:0] time_q;

  // Result register.
  logic         out_valid_q;
  press_event_e out_event_q;
  press_event_e core_event;

  logic out_free;
  logic advance;
  logic accept;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  // Register writes; the index comes from the word address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms      <= DebounceMsRst;
      cfg_q.long_press_ticks <= LongPressRst;
      cfg_q.click_gap_ticks  <= ClickGapRst;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        RegDebounceMs: cfg_q.debounce_ms      <= pwdata[TimeW-1:0];
        RegLongPress:  cfg_q.long_press_ticks <= pwdata[ThreshW-1:0];
        RegClickGap:   cfg_q.click_gap_ticks  <= pwdata[ThreshW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegDebounceMs: prdata = ApbDataW'(cfg_q.debounce_ms);
      RegLongPress:  prdata = ApbDataW'(cfg_q.long_press_ticks);
      RegClickGap:   prdata = ApbDataW'(cfg_q.click_gap_ticks);
      default:       prdata = '0;
    endcase
  end

  // The result register is free when empty or being drained this cycle.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q  <= s_axis_tdata[0];
      time_q <= s_axis_tdata[TimeW:1];
    end
    if (advance) begin
      out_event_q <= core_event;
    end
  end

  bclp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .key_level_i (key_q),
    .time_ms_i   (time_q),
    .cfg_i       (cfg_q),
    .event_o     (core_event)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_event_q);

endmodule

`default_nettype wire

FILE: sv/bclp_chk.sv
// Port-level checker for the button click and long-press classifier and the
// bind that attaches it to the top level. Depends on bclp_pkg.
`default_nettype none

module bclp_chk import bclp_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or vanished");

  // Every accepted request has a result pending once past the input register: it
  // either moved into the result register or the receiver still holds the result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
    else $error("accepted request produced no pending result");

  // With no result pending, the block always takes a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("slave side stalled with empty result register");

  // Padding bits of the result stay zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1:2] == '0)
    else $error("result padding bits not zero");

endmodule

bind button_click_long_press_classifier_unit bclp_chk u_bclp_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: dv/tb_button_click_long_press_classifier_unit.sv
// Testbench for button_click_long_press_classifier_unit: sends poll-tick requests on the
// slave stream, predicts the press event of each one and checks every result in order.
// Depends on bclp_pkg and the block's RTL; nothing else.
module tb_button_click_long_press_classifier_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bclp_pkg::*;

  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned ResetCycles = 8;
  localparam int unsigned DrainCycles = 8;
  // Watchdog limit on the cycle count; this is far beyond the slowest legal run.
  localparam int unsigned CycleLimit  = 200000;
  // Cap, in ticks, on each threshold-derived length that a gesture segment is built from.
  localparam int unsigned GestureCap  = 40;
  // Register index past the end of the map; writes to it must be ignored.
  localparam logic [1:0]  RegUnmapped = 2'd3;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;  // [0] key_level, [16:1] time_ms
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // [1:0] press_event
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ApbAddrW-1:0] paddr         = '0;
  logic [ApbDataW-1:0] pwdata        = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // Shadow copy of the registers and of the classifier state, starting at reset values.
  cfg_t cfg_now = '{debounce_ms: DebounceMsRst, long_press_ticks: LongPressRst,
                    click_gap_ticks: ClickGapRst};
  logic                       key_prev      = 1'b1;
  logic                       key_accepted  = 1'b1;
  logic                       bounce_timing = 1'b0;
  logic [TimeW-1:0]           bounce_stamp  = '0;
  logic [CountW-1:0]          held_count    = '0;
  logic [CountW-1:0]          gap_count     = '0;
  logic signed [TallyW-1:0]   click_count   = '0;

  press_event_e expected_presses[$];

  int unsigned      fail_count     = 0;
  int unsigned      items_sent     = 0;
  int unsigned      cycle_count    = 0;
  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      hold_off_left  = 0;
  logic [TimeW-1:0] now_ms         = '0;

  button_click_long_press_classifier_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("button_click_long_press_classifier_unit verification failed");
    $finish;
  end

  // One poll tick through the debouncer and the press classifier. Returns the event that
  // the tick reports and advances the shadow state.
  function automatic press_event_e classify_poll(input logic key, input logic [TimeW-1:0] now);
    press_event_e     ev;
    logic             old_lvl;
    logic [TimeW-1:0] elapsed;
    ev = EV_NONE;
    // A new difference from the last accepted level starts the timer. When the timer runs
    // out, whatever level is present on that tick is taken, even the old one again.
    if (key != key_prev && !bounce_timing) begin
      bounce_stamp  = now;
      bounce_timing = 1'b1;
    end else if (bounce_timing) begin
      elapsed = now - bounce_stamp;
      if (elapsed > cfg_now.debounce_ms) begin
        bounce_timing = 1'b0;
        key_accepted  = key;
      end
    end
    old_lvl  = key_prev;
    key_prev = key_accepted;
    if (key_accepted && !old_lvl) begin
      // Release edge: one more click, unless a long press just ended (tally at -1).
      held_count = '0;
      if (click_count < TallyMax) click_count = click_count + 8'sd1;
    end else if (!key_accepted && !old_lvl) begin
      // Still held: the long press repeats on every tick past the threshold.
      if (held_count != CountMax) held_count = held_count + CountW'(1);
      if (held_count > CountW'(cfg_now.long_press_ticks)) begin
        click_count = TallyLong;
        ev          = EV_LONG;
      end
    end else if (click_count > 8'sd0) begin
      // Clicks pending: the gap counter also runs on a press edge and is only cleared
      // when the clicks are reported.
      if (gap_count != CountMax) gap_count = gap_count + CountW'(1);
      if (gap_count > CountW'(cfg_now.click_gap_ticks)) begin
        ev          = (click_count == 8'sd1) ? EV_SINGLE : EV_DOUBLE;
        gap_count   = '0;
        click_count = '0;
      end
    end
    return ev;
  endfunction

  function automatic int unsigned gesture_len(input int unsigned v);
    return (v > GestureCap) ? GestureCap : v;
  endfunction

  // Sends one poll tick, with random idle cycles ahead of it, and records its prediction
  // at the edge where the request is taken. tvalid is left high when the task returns.
  task automatic send_tick(input logic key, input logic [TimeW-1:0] stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({stamp, key});
    do @(posedge clk_i); while (!s_axis_tready);
    expected_presses.push_back(classify_poll(key, stamp));
    items_sent++;
  endtask

  // Drops tvalid and waits until every predicted result has come back.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_presses.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Setup phase, access phase, then psel is dropped before the task returns.
  task automatic write_reg(input logic [1:0] idx, input logic [ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegDebounceMs: cfg_now.debounce_ms      = value[TimeW-1:0];
      RegLongPress:  cfg_now.long_press_ticks = value[ThreshW-1:0];
      RegClickGap:   cfg_now.click_gap_ticks  = value[ThreshW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Writes all three registers once the block is idle; the bits above each register carry
  // random garbage that must be dropped.
  task automatic apply_settings(input logic [TimeW-1:0] deb, input logic [ThreshW-1:0] lp,
                                input logic [ThreshW-1:0] gap);
    wait_idle();
    write_reg(RegDebounceMs, {16'($urandom), deb});
    write_reg(RegLongPress, {8'($urandom), lp});
    write_reg(RegClickGap, {8'($urandom), gap});
  endtask

  // Holds a key level for a number of ticks, 1 or 2 ms apart; with bounce the first few
  // ticks may show the opposite level.
  task automatic hold_key(input logic key, input int unsigned n_ticks, input bit bouncy);
    logic lvl;
    for (int unsigned i = 0; i < n_ticks; i++) begin
      lvl = key;
      if (bouncy && i < 3 && $urandom_range(1) == 1) lvl = ~key;
      now_ms += TimeW'($urandom_range(2, 1));
      send_tick(lvl, now_ms);
    end
  endtask

  // One to three clicks with random press and release lengths scaled to the current
  // thresholds, so single, double and long presses all come up, then a quiet stretch.
  task automatic play_gesture();
    int unsigned clicks, deb_t, lp_t, gap_t;
    deb_t  = gesture_len(32'(cfg_now.debounce_ms));
    lp_t   = gesture_len(32'(cfg_now.long_press_ticks));
    gap_t  = gesture_len(32'(cfg_now.click_gap_ticks));
    clicks = $urandom_range(3, 1);
    for (int unsigned c = 0; c < clicks; c++) begin
      hold_key(1'b0, deb_t + $urandom_range(lp_t + 4, 1), 1'b1);
      hold_key(1'b1, deb_t + $urandom_range(gap_t, 1), 1'b1);
    end
    hold_key(1'b1, deb_t + gap_t + $urandom_range(6, 2), 1'b0);
  endtask

  // Random levels, some with times jumping anywhere in the 16-bit range.
  task automatic play_noise();
    int unsigned n;
    n = $urandom_range(8, 1);
    repeat (n) begin
      if ($urandom_range(3) == 0) now_ms = TimeW'($urandom);
      else now_ms += TimeW'($urandom_range(3));
      send_tick(1'($urandom_range(1)), now_ms);
    end
  endtask

  task automatic run_traffic(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 80) play_gesture();
      else play_noise();
    end
  endtask

  task automatic run_phase(input logic [TimeW-1:0] deb, input logic [ThreshW-1:0] lp,
                           input logic [ThreshW-1:0] gap, input int unsigned send_pct,
                           input int unsigned stall_pct, input int unsigned n_items);
    apply_settings(deb, lp, gap);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    now_ms         = TimeW'($urandom);
    run_traffic(n_items);
  endtask

  // Reset values: a press that is back up on the tick where the 9 ms run out, so the
  // debouncer takes the released level again when it expires.
  task automatic test_reset_defaults();
    send_tick(1'b0, 16'd100);
    send_tick(1'b0, 16'd105);
    send_tick(1'b1, 16'd110);
  endtask

  // Zero debounce time and a difference that wraps from the top of the time range.
  task automatic test_debounce_wrap();
    apply_settings(16'd0, 24'd2, 24'd2);
    send_tick(1'b0, 16'hFFFF);
    send_tick(1'b0, 16'h0000);
  endtask

  // The key is already down: the hold passes the threshold, keeps reporting, and the
  // release after it counts no click.
  task automatic test_long_press_hold();
    now_ms = 16'd0;
    repeat (4) begin
      now_ms++;
      send_tick(1'b0, now_ms);
    end
    repeat (2) begin
      now_ms++;
      send_tick(1'b1, now_ms);
    end
  endtask

  // Two quick clicks; the gap counter keeps running across the second press edge.
  task automatic test_double_click();
    logic key_seq[9] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};
    foreach (key_seq[i]) begin
      now_ms++;
      send_tick(key_seq[i], now_ms);
    end
  endtask

  // Several register settings, the range limits among them, under each idling mode.
  task automatic test_random_phases();
    run_phase(16'd1, 24'd12, 24'd6, 0, 0, 210);
    run_phase(16'd0, 24'd1, 24'd1, 66, 0, 210);
    run_phase(16'd3, 24'd20, 24'd10, 0, 66, 210);
    // Thresholds at the bottom of their range: every nonzero count exceeds them.
    run_phase(16'd0, 24'd0, 24'd0, 10, 10, 260);
    // Top of every range: no level is ever accepted and no press is reported.
    run_phase(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 120);
    run_phase(16'd2, 24'd9, 24'd5, 66, 66, 220);
  endtask

  // A write past the register map must leave the settings alone.
  task automatic test_unmapped_write();
    wait_idle();
    write_reg(RegUnmapped, $urandom);
    run_traffic(40);
  endtask

  // The receiver holds off long enough for the block to fill and drop its tready while
  // the sender keeps offering requests.
  task automatic test_receiver_hold_off();
    apply_settings(16'd2, 24'd15, 24'd8);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 300;
    run_traffic(150);
  endtask

  // Receiver: random stalls per cycle, or a counted hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_left > 0) begin
        hold_off_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Every result taken is compared with the oldest prediction.
  always @(posedge clk_i) begin
    press_event_e want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_presses.size() == 0) begin
        $display("%0t: press event %0d with no request outstanding", $time,
                 m_axis_tdata[1:0]);
        fail_count++;
      end else begin
        want = expected_presses.pop_front();
        if (m_axis_tdata[1:0] !== want) begin
          $display("%0t: press event mismatch, expected %0d, actual %0d", $time, want,
                   m_axis_tdata[1:0]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_debounce_wrap();
    test_long_press_hold();
    test_double_click();
    test_random_phases();
    test_unmapped_write();
    test_receiver_hold_off();
    wait_idle();
    if (fail_count == 0 && expected_presses.size() == 0) begin
      $display("button_click_long_press_classifier_unit verification clean");
    end else begin
      $display("button_click_long_press_classifier_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/bclp_pkg.sv
sv/bclp_core.sv
sv/button_click_long_press_classifier_unit.sv
sv/bclp_chk.sv
dv/tb_button_click_long_press_classifier_unit.sv
